>>> hdl/kni_lex_pkg.sv
// Shared types, constants and reset state for the keyword/number/identifier lexer.
// No dependencies; imported by kni_lex_step, keyword_number_identifier_lexer, kni_token_checker and testbench.
package kni_lex_pkg;

  localparam int OFFSET_BITS = 16;

  // token kinds
  localparam logic [3:0] KIND_NETWORK    = 4'd0;
  localparam logic [3:0] KIND_INPUT      = 4'd1;
  localparam logic [3:0] KIND_LBRACE     = 4'd2;
  localparam logic [3:0] KIND_RBRACE     = 4'd3;
  localparam logic [3:0] KIND_LAYER      = 4'd4;
  localparam logic [3:0] KIND_WEIGHTS    = 4'd5;
  localparam logic [3:0] KIND_BIAS       = 4'd6;
  localparam logic [3:0] KIND_ACTIVATION = 4'd7;
  localparam logic [3:0] KIND_LBRACKET   = 4'd8;
  localparam logic [3:0] KIND_RBRACKET   = 4'd9;
  localparam logic [3:0] KIND_COLON      = 4'd10;
  localparam logic [3:0] KIND_NUMBER     = 4'd11;
  localparam logic [3:0] KIND_IDENT      = 4'd12;
  localparam logic [3:0] KIND_END        = 4'd13;
  localparam logic [3:0] KIND_INVALID    = 4'd14;

  // character codes
  localparam logic [7:0] CH_LBRACE     = 8'h7B;
  localparam logic [7:0] CH_RBRACE     = 8'h7D;
  localparam logic [7:0] CH_LBRACKET   = 8'h5B;
  localparam logic [7:0] CH_RBRACKET   = 8'h5D;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_PLUS       = 8'h2B;
  localparam logic [7:0] CH_MINUS      = 8'h2D;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  localparam int KW_COUNT = 6;
  localparam int KW_SLOTS = 16;

  // keyword spellings, zero padded; entries past the length are never compared
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
    '{0:"n", 1:"e", 2:"t", 3:"w", 4:"o", 5:"r", 6:"k", default:8'h00},
    '{0:"i", 1:"n", 2:"p", 3:"u", 4:"t", default:8'h00},
    '{0:"l", 1:"a", 2:"y", 3:"e", 4:"r", default:8'h00},
    '{0:"w", 1:"e", 2:"i", 3:"g", 4:"h", 5:"t", 6:"s", default:8'h00},
    '{0:"b", 1:"i", 2:"a", 3:"s", default:8'h00},
    '{0:"a", 1:"c", 2:"t", 3:"i", 4:"v", 5:"a", 6:"t", 7:"i", 8:"o", 9:"n",
      default:8'h00}
  };
  localparam logic [15:0] KW_LEN [KW_COUNT] = '{16'd7, 16'd5, 16'd5, 16'd7, 16'd4, 16'd10};
  localparam logic [3:0] KW_KIND [KW_COUNT] = '{
    KIND_NETWORK, KIND_INPUT, KIND_LAYER, KIND_WEIGHTS, KIND_BIAS, KIND_ACTIVATION
  };

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_SIGN,
    PH_DIGITS,
    PH_NOT_NUMBER
  } num_phase_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    logic [3:0]         token_kind;
    logic [15:0]        start_offset;
    logic [15:0]        token_length;
    logic signed [63:0] number_value;
    logic               last_of_run;
  } token_item_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] byte_position;
    logic [OFFSET_BITS-1:0] pending_start;
    logic [15:0]            pending_length;
    logic [KW_COUNT-1:0]    keyword_candidates;
    num_phase_t             number_phase;
    logic                   number_negative;
    logic [63:0]            number_magnitude;
    logic                   identifier_valid;
    logic                   halted_on_error;
  } lex_state_t;

  function automatic lex_state_t lex_reset();
    lex_state_t s;
    s.byte_position      = '0;
    s.pending_start      = '0;
    s.pending_length     = '0;
    s.keyword_candidates = '1;
    s.number_phase       = PH_EMPTY;
    s.number_negative    = 1'b0;
    s.number_magnitude   = '0;
    s.identifier_valid   = 1'b1;
    s.halted_on_error    = 1'b0;
    return s;
  endfunction

  // cut or widen an offset to the 16-bit result field
  function automatic logic [15:0] offset16(input logic [OFFSET_BITS-1:0] pos);
    logic [31:0] wide;
    wide = 32'(pos);
    return wide[15:0];
  endfunction

endpackage

>>> hdl/kni_lex_step.sv
// One lexer step: next state and up to three tokens for one text item.
// Depends on kni_lex_pkg.
module kni_lex_step
  import kni_lex_pkg::*;
(
  input  lex_state_t        cur,
  input  text_item_t        item,
  output lex_state_t        nxt,
  output token_item_t [2:0] res,
  output logic [1:0]        res_count
);

  function automatic token_item_t classify(input lex_state_t s);
    token_item_t t;
    logic        found;
    found          = 1'b0;
    t.token_kind   = KIND_INVALID;
    t.start_offset = offset16(s.pending_start);
    t.token_length = s.pending_length;
    t.number_value = '0;
    t.last_of_run  = 1'b0;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (s.keyword_candidates[k] && s.pending_length == KW_LEN[k]) begin
        found        = 1'b1;
        t.token_kind = KW_KIND[k];
      end
    end
    if (!found) begin
      if (s.number_phase == PH_DIGITS) begin
        t.token_kind   = KIND_NUMBER;
        t.number_value = s.number_negative ? -s.number_magnitude : s.number_magnitude;
      end else if (s.identifier_valid) begin
        t.token_kind = KIND_IDENT;
      end
    end
    return t;
  endfunction

  function automatic lex_state_t clear_pending(input lex_state_t s);
    lex_state_t r;
    r                 = lex_reset();
    r.byte_position   = s.byte_position;
    r.halted_on_error = s.halted_on_error;
    return r;
  endfunction

  logic        active;
  logic        is_delim;
  logic        is_space;
  logic [3:0]  delim_kind;
  lex_state_t  added;
  lex_state_t  mid;
  token_item_t flushed;
  token_item_t delim_tok;
  token_item_t end_tok;
  logic        e_flush_old;
  logic        e_delim;
  logic        e_flush_end;
  logic        halted_mid;

  assign active = item.byte_present && !cur.halted_on_error;

  always_comb begin
    is_delim   = 1'b0;
    is_space   = 1'b0;
    delim_kind = KIND_LBRACE;
    unique case (item.text_byte) inside
      CH_LBRACE:          begin is_delim = 1'b1; delim_kind = KIND_LBRACE;   end
      CH_RBRACE:          begin is_delim = 1'b1; delim_kind = KIND_RBRACE;   end
      CH_LBRACKET:        begin is_delim = 1'b1; delim_kind = KIND_LBRACKET; end
      CH_RBRACKET:        begin is_delim = 1'b1; delim_kind = KIND_RBRACKET; end
      CH_COLON:           begin is_delim = 1'b1; delim_kind = KIND_COLON;    end
      [CH_TAB:CH_CR], CH_SPACE: is_space = 1'b1;
      default: ;
    endcase
  end

  // append the byte to the pending token
  always_comb begin
    logic [7:0]  c;
    logic [15:0] idx;
    logic        digit;
    logic        alpha;
    logic [63:0] limit;
    logic [67:0] acc;
    c     = item.text_byte;
    idx   = cur.pending_length;
    digit = (c >= "0") && (c <= "9");
    alpha = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    limit = cur.number_negative ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
    acc   = {1'b0, cur.number_magnitude, 3'b000} + {3'b000, cur.number_magnitude, 1'b0}
            + {60'd0, c - 8'h30};
    added = cur;
    if (idx == 16'd0) added.pending_start = cur.byte_position;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (idx >= KW_LEN[k] || KW_TEXT[k][idx[3:0]] != c)
        added.keyword_candidates[k] = 1'b0;
    end
    if ((idx == 16'd0 && digit) || !(digit || alpha || c == CH_UNDERSCORE))
      added.identifier_valid = 1'b0;
    if (digit && cur.number_phase != PH_NOT_NUMBER) begin
      if (acc > {4'd0, limit}) begin
        added.number_phase = PH_NOT_NUMBER;
      end else begin
        added.number_magnitude = acc[63:0];
        added.number_phase     = PH_DIGITS;
      end
    end else if (idx == 16'd0 && (c == CH_PLUS || c == CH_MINUS)) begin
      added.number_phase    = PH_SIGN;
      added.number_negative = (c == CH_MINUS);
    end else begin
      added.number_phase = PH_NOT_NUMBER;
    end
    if (cur.pending_length != 16'hFFFF) added.pending_length = cur.pending_length + 16'd1;
  end

  // one classifier: the appended state only matters when end follows a token byte
  assign flushed = classify((active && !is_delim && !is_space) ? added : cur);

  assign e_flush_old = active && (is_delim || is_space) && (cur.pending_length != 16'd0);
  assign halted_mid  = cur.halted_on_error
                       || (e_flush_old && flushed.token_kind == KIND_INVALID);
  assign e_delim     = active && is_delim && !halted_mid;

  always_comb begin
    if (!active) mid = cur;
    else if (is_delim || is_space) mid = e_flush_old ? clear_pending(cur) : cur;
    else mid = added;
    mid.halted_on_error = halted_mid;
    if (item.byte_present) mid.byte_position = cur.byte_position + 1'b1;
  end

  assign e_flush_end = item.end_of_text && !halted_mid && (mid.pending_length != 16'd0);

  always_comb begin
    delim_tok.token_kind   = delim_kind;
    delim_tok.start_offset = offset16(cur.byte_position);
    delim_tok.token_length = 16'd1;
    delim_tok.number_value = '0;
    delim_tok.last_of_run  = 1'b0;
    end_tok.token_kind     = KIND_END;
    end_tok.start_offset   = offset16(mid.byte_position);
    end_tok.token_length   = 16'd0;
    end_tok.number_value   = '0;
    end_tok.last_of_run    = 1'b0;
  end

  // pack the tokens in order into the result slots
  always_comb begin
    logic [1:0] n;
    n   = 2'd0;
    res = '0;
    if (e_flush_old) begin res[n] = flushed; n = n + 2'd1; end
    if (e_delim) begin res[n] = delim_tok; n = n + 2'd1; end
    if (e_flush_end) begin res[n] = flushed; n = n + 2'd1; end
    if (item.end_of_text) begin res[n] = end_tok; n = n + 2'd1; end
    if (n != 2'd0) res[n - 2'd1].last_of_run = 1'b1;
    res_count = n;
  end

  assign nxt = item.end_of_text ? lex_reset() : mid;

endmodule

>>> hdl/keyword_number_identifier_lexer.sv
// A text request that is taken goes into the input register, then, once the result buffer
// is free, its tokens are loaded into the result buffer. Throughput: one request per cycle
// while each gives at most one token and the receiver does not stall; a request giving more
// tokens holds the next one until the single token port has drained the three-entry buffer.
// Reset: synchronous, active high; clears the pipeline and all lexer state at once.
// Top level of the lexer; depends on kni_lex_pkg and kni_lex_step.
module keyword_number_identifier_lexer
  import kni_lex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  output logic        text_stall,
  input  text_item_t  text,
  output logic        token_valid,
  input  logic        token_stall,
  output token_item_t token
);

  logic              s1_valid;
  text_item_t        s1_item;
  lex_state_t        st;
  lex_state_t        st_next;
  token_item_t [2:0] step_res;
  logic [1:0]        step_count;
  token_item_t [2:0] buf_res;
  logic [1:0]        cnt;
  logic              tok_acc;
  logic              buf_free;
  logic              s1_adv;
  logic              text_acc;

  kni_lex_step u_step (
    .cur       (st),
    .item      (s1_item),
    .nxt       (st_next),
    .res       (step_res),
    .res_count (step_count)
  );

  assign tok_acc    = token_valid && !token_stall;
  assign buf_free   = (cnt == 2'd0) || (cnt == 2'd1 && tok_acc);
  assign s1_adv     = s1_valid && buf_free;
  assign text_stall = s1_valid && !buf_free;
  assign text_acc   = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (text_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (text_acc) s1_item <= text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= lex_reset();
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // result buffer: load a whole batch, shift out one token each time the receiver takes one
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (s1_adv) begin
      cnt <= step_count;
    end else if (tok_acc) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      buf_res <= step_res;
    end else if (tok_acc) begin
      buf_res[0] <= buf_res[1];
      buf_res[1] <= buf_res[2];
    end
  end

  assign token_valid = (cnt != 2'd0);
  assign token       = buf_res[0];

`ifndef SYNTH
  a_batch_loaded: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> cnt == $past(step_count))
    else $error("result buffer count does not match loaded batch");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind == KIND_END |-> token.last_of_run
      && token.token_length == 16'd0)
    else $error("end token not last of run or has nonzero length");

  a_value_only_numbers: assert property (@(posedge clk) disable iff (rst)
    token_valid && token.token_kind != KIND_NUMBER |-> token.number_value == 64'sd0)
    else $error("nonzero value on a non-number token");

  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> st.pending_length == 16'd0 && !st.halted_on_error && !s1_valid
      && cnt == 2'd0)
    else $error("lexer state not clean after reset");
`endif

endmodule

>>> tb/sv/kni_token_checker.sv
// Token checker for keyword_number_identifier_lexer: watches both channels,
// predicts the tokens of every accepted text request and compares them in order.
// Depends on kni_lex_pkg for the payload types, token kinds and keyword spellings.
`timescale 1ns / 1ps

module kni_token_checker
  import kni_lex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        text_valid,
  input  logic        text_stall,
  input  text_item_t  text,
  input  logic        token_valid,
  input  logic        token_stall,
  input  token_item_t token,
  output int          errors,
  output int          outstanding
);

  token_item_t expected_tokens[$];

  // lexer state as predicted
  logic [OFFSET_BITS-1:0] cur_pos;
  logic [OFFSET_BITS-1:0] tok_start;
  logic [15:0]            tok_len;
  logic [KW_COUNT-1:0]    kw_alive;
  num_phase_t             num_phase;
  logic                   num_neg;
  logic [63:0]            num_mag;
  logic                   ident_ok;
  logic                   halted;

  token_item_t batch [3];
  int          batch_n;

  initial begin
    errors = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic clear_token();
    tok_start = '0;
    tok_len   = '0;
    kw_alive  = '1;
    num_phase = PH_EMPTY;
    num_neg   = 1'b0;
    num_mag   = '0;
    ident_ok  = 1'b1;
  endtask

  task automatic push_token(logic [3:0] kind, logic [OFFSET_BITS-1:0] start,
                            logic [15:0] len, logic [63:0] value);
    token_item_t t;
    logic [31:0] wide;
    wide = 32'(start);
    t.token_kind   = kind;
    t.start_offset = wide[15:0];
    t.token_length = len;
    t.number_value = value;
    t.last_of_run  = 1'b0;
    batch[batch_n] = t;
    batch_n++;
  endtask

  // class the pending token: keyword first, then number, then identifier
  task automatic close_token();
    logic [3:0]  kind;
    logic [63:0] value;
    logic        found;
    kind  = KIND_INVALID;
    value = '0;
    found = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!found && kw_alive[k] && tok_len == KW_LEN[k]) begin
        kind  = KW_KIND[k];
        found = 1'b1;
      end
    end
    if (!found) begin
      if (num_phase == PH_DIGITS) begin
        kind  = KIND_NUMBER;
        value = num_neg ? (~num_mag + 64'd1) : num_mag;
      end else if (ident_ok) begin
        kind = KIND_IDENT;
      end
    end
    push_token(kind, tok_start, tok_len, value);
    if (kind == KIND_INVALID) halted = 1'b1;
    clear_token();
  endtask

  task automatic extend_token(logic [7:0] c);
    logic        digit;
    logic        alpha;
    logic [63:0] limit;
    logic [63:0] d;
    digit = (c >= "0" && c <= "9");
    alpha = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    if (tok_len == 0) tok_start = cur_pos;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (tok_len >= KW_LEN[k]) kw_alive[k] = 1'b0;
      else if (KW_TEXT[k][tok_len[3:0]] != c) kw_alive[k] = 1'b0;
    end
    if ((tok_len == 0 && digit) || !(digit || alpha || c == CH_UNDERSCORE)) ident_ok = 1'b0;
    if (digit && num_phase != PH_NOT_NUMBER) begin
      limit = num_neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      d = {56'd0, c - 8'h30};
      // drop out of the number class before the magnitude leaves the signed range
      if (num_mag > (limit - d) / 64'd10) begin
        num_phase = PH_NOT_NUMBER;
      end else begin
        num_mag   = num_mag * 64'd10 + d;
        num_phase = PH_DIGITS;
      end
    end else if (tok_len == 0 && (c == CH_PLUS || c == CH_MINUS)) begin
      num_phase = PH_SIGN;
      num_neg   = (c == CH_MINUS);
    end else begin
      num_phase = PH_NOT_NUMBER;
    end
    if (tok_len != 16'hFFFF) tok_len++;
  endtask

  task automatic tokenize_item(text_item_t it);
    logic [3:0] dkind;
    logic       is_delim;
    batch_n  = 0;
    dkind    = KIND_INVALID;
    is_delim = 1'b1;
    if (it.byte_present && !halted) begin
      case (it.text_byte)
        CH_LBRACE:   dkind = KIND_LBRACE;
        CH_RBRACE:   dkind = KIND_RBRACE;
        CH_LBRACKET: dkind = KIND_LBRACKET;
        CH_RBRACKET: dkind = KIND_RBRACKET;
        CH_COLON:    dkind = KIND_COLON;
        default:     is_delim = 1'b0;
      endcase
      if (is_delim) begin
        if (tok_len != 0) close_token();
        // a delimiter that ended an invalid token is swallowed
        if (!halted) push_token(dkind, cur_pos, 16'd1, 64'd0);
      end else if (it.text_byte == CH_SPACE ||
                   (it.text_byte >= CH_TAB && it.text_byte <= CH_CR)) begin
        if (tok_len != 0) close_token();
      end else begin
        extend_token(it.text_byte);
      end
    end
    if (it.byte_present) cur_pos = cur_pos + 1'b1;
    if (it.end_of_text) begin
      if (!halted && tok_len != 0) close_token();
      push_token(KIND_END, cur_pos, 16'd0, 64'd0);
      cur_pos = '0;
      halted  = 1'b0;
      clear_token();
    end
    if (batch_n > 0) batch[batch_n - 1].last_of_run = 1'b1;
    for (int i = 0; i < batch_n; i++) expected_tokens.insert(expected_tokens.size(), batch[i]);
  endtask

  task automatic compare_token(token_item_t got);
    token_item_t want;
    if (expected_tokens.size() == 0) begin
      report_mismatch("token with nothing expected", 64'(got.token_kind), 64'd0);
    end else begin
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        report_mismatch("token_kind", 64'(got.token_kind), 64'(want.token_kind));
      if (got.start_offset !== want.start_offset)
        report_mismatch("start_offset", 64'(got.start_offset), 64'(want.start_offset));
      if (got.token_length !== want.token_length)
        report_mismatch("token_length", 64'(got.token_length), 64'(want.token_length));
      if (got.number_value !== want.number_value)
        report_mismatch("number_value", got.number_value, want.number_value);
      if (got.last_of_run !== want.last_of_run)
        report_mismatch("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cur_pos = '0;
      halted  = 1'b0;
      clear_token();
      expected_tokens.delete();
    end else begin
      if (token_valid && !token_stall) compare_token(token);
      if (text_valid && !text_stall) tokenize_item(text);
    end
    outstanding = expected_tokens.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the lexer testbench: clock, reset, text stimulus and token back-pressure.
// Instantiates keyword_number_identifier_lexer and kni_token_checker; uses kni_lex_pkg.
`timescale 1ns / 1ps

module testbench;
  import kni_lex_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        text_valid = 1'b0;
  logic        text_stall;
  text_item_t  text = '0;
  logic        token_valid;
  logic        token_stall = 1'b0;
  token_item_t token;

  int   errors;
  int   outstanding;
  logic text_took = 1'b0;
  bit   hold_go = 1'b0;
  bit   hold_done = 1'b0;
  bit   no_gaps = 1'b0;
  int   burst_left = 0;
  int   sent = 0;

  logic [7:0] text_chars[$];

  keyword_number_identifier_lexer uut (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_stall(text_stall), .text(text),
    .token_valid(token_valid), .token_stall(token_stall), .token(token)
  );

  kni_token_checker tok_check (
    .clk(clk), .rst(rst),
    .text_valid(text_valid), .text_stall(text_stall), .text(text),
    .token_valid(token_valid), .token_stall(token_stall), .token(token),
    .errors(errors), .outstanding(outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // record at each edge whether the text request was taken
  always @(posedge clk) text_took <= text_valid && !text_stall;

  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

  // offer one request and hold it until taken; bursts and gaps between them
  task automatic put(logic [7:0] b, logic present, logic eot);
    text_item_t it;
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    it.text_byte    = b;
    it.byte_present = present;
    it.end_of_text  = eot;
    text       <= it;
    text_valid <= 1'b1;
    @(negedge clk);
    while (!text_took) @(negedge clk);
    burst_left--;
    if (present || eot) sent++;
  endtask

  task automatic append_char(logic [7:0] c);
    text_chars.insert(text_chars.size(), c);
  endtask

  task automatic add_string(string s);
    for (int i = 0; i < s.len(); i++) append_char(s[i]);
  endtask

  function automatic logic [7:0] pick_word_char(bit first);
    int r;
    r = $urandom_range(0, first ? 52 : 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return CH_UNDERSCORE;
    return 8'h30 + 8'(r - 53);
  endfunction

  task automatic add_keyword();
    int k;
    int m;
    int n;
    k = $urandom_range(0, KW_COUNT - 1);
    m = $urandom_range(0, 5);
    n = (m == 4) ? int'(KW_LEN[k]) - 1 : int'(KW_LEN[k]);
    for (int i = 0; i < n; i++) append_char(KW_TEXT[k][i]);
    if (m == 5) append_char(pick_word_char(1'b0));
  endtask

  task automatic add_number();
    int sign;
    int n;
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 6))
        0: add_string("9223372036854775807");
        1: add_string("-9223372036854775808");
        2: add_string("9223372036854775808");
        3: add_string("-9223372036854775809");
        4: add_string("+0");
        5: add_string("00012");
        default: add_string("99999999999999999999999");
      endcase
    end else begin
      sign = $urandom_range(0, 2);
      if (sign == 1) append_char(CH_PLUS);
      if (sign == 2) append_char(CH_MINUS);
      n = $urandom_range(1, 6);
      repeat (n) append_char(8'h30 + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic add_identifier();
    int n;
    append_char(pick_word_char(1'b1));
    n = $urandom_range(0, 7);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: append_char(8'h00);
          1: append_char(8'($urandom_range(128, 255)));
          2: append_char(8'h24);
          default: append_char(CH_MINUS);
        endcase
      end else begin
        append_char(pick_word_char(1'b0));
      end
    end
  endtask

  task automatic add_delimiter();
    case ($urandom_range(0, 4))
      0: append_char(CH_LBRACE);
      1: append_char(CH_RBRACE);
      2: append_char(CH_LBRACKET);
      3: append_char(CH_RBRACKET);
      default: append_char(CH_COLON);
    endcase
  endtask

  // mostly well-formed tokens with whitespace between, some noise and broken words
  task automatic make_text(int min_tokens);
    int n;
    int r;
    text_chars.delete();
    n = $urandom_range(min_tokens, min_tokens + 7);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 25) add_keyword();
      else if (r < 45) add_number();
      else if (r < 65) add_identifier();
      else if (r < 85) add_delimiter();
      else if (r < 93) append_char(8'($urandom_range(0, 255)));
      else begin
        append_char(8'h30 + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(1, 3)) append_char(pick_word_char(1'b1));
      end
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(1, 2)) begin
          if ($urandom_range(0, 1) == 0) append_char(CH_SPACE);
          else append_char(8'($urandom_range(9, 13)));
        end
      end
    end
  endtask

  task automatic send_text();
    bit end_with_byte;
    int n;
    end_with_byte = $urandom_range(0, 1);
    n = text_chars.size();
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) put(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (i == n - 1 && end_with_byte) put(text_chars[i], 1'b1, 1'b1);
      else put(text_chars[i], 1'b1, 1'b0);
    end
    if (!end_with_byte || n == 0) put(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    text_valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  // receiver: stretches of differing stall patterns, plus one long hold-off
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 4);
      len  = $urandom_range(8, 80);
      repeat (len) begin
        @(negedge clk);
        if (hold_go && !hold_done) begin
          token_stall <= 1'b1;
          repeat (300) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: token_stall <= 1'b0;
          1: token_stall <= 1'($urandom_range(0, 1));
          2: token_stall <= ($urandom_range(0, 7) == 0);
          3: token_stall <= ~token_stall;
          default: token_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin
    int texts;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // delimiters, whitespace, control and high bytes, halting and end forms
    put(CH_LBRACE, 1'b1, 1'b0);
    put("a", 1'b1, 1'b0);
    put(CH_RBRACE, 1'b1, 1'b0);
    put(CH_LBRACKET, 1'b1, 1'b0);
    put(CH_COLON, 1'b1, 1'b0);
    put(CH_RBRACKET, 1'b1, 1'b0);
    put(CH_TAB, 1'b1, 1'b0);
    put("7", 1'b1, 1'b0);
    put(CH_CR, 1'b1, 1'b0);
    put(8'h00, 1'b0, 1'b0);
    put(8'h00, 1'b1, 1'b0);
    put(CH_SPACE, 1'b1, 1'b0);
    put("x", 1'b1, 1'b0);
    put(CH_LBRACE, 1'b1, 1'b0);
    put(8'h00, 1'b0, 1'b1);
    put(8'hFF, 1'b1, 1'b1);
    put(CH_MINUS, 1'b1, 1'b0);
    put("5", 1'b1, 1'b0);
    put(CH_SPACE, 1'b1, 1'b1);
    put(CH_PLUS, 1'b1, 1'b0);
    put(8'hFF, 1'b0, 1'b1);
    put("9", 1'b1, 1'b0);
    put("b", 1'b1, 1'b0);
    put(CH_COLON, 1'b1, 1'b1);
    put(8'hA5, 1'b0, 1'b0);

    texts = 0;
    while (sent < 380) begin
      if (texts == 3) begin
        // back-to-back text while the receiver holds off
        hold_go = 1'b1;
        no_gaps = 1'b1;
        make_text(14);
        send_text();
        no_gaps = 1'b0;
      end else begin
        make_text(1);
        send_text();
      end
      if (texts == 1 || $urandom_range(0, 7) == 0) wait_drained();
      texts++;
    end

    text_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/kni_lex_pkg.sv
hdl/kni_lex_step.sv
hdl/keyword_number_identifier_lexer.sv
tb/sv/kni_token_checker.sv
tb/sv/testbench.sv
